FILE: src/murmur3_32_stream_hash_defines.svh
// Assertion macros shared by the murmur3 stream hash RTL.
// Depends on nothing; the including module must have aclk and aresetn.
`ifndef MURMUR3_32_STREAM_HASH_DEFINES_SVH
`define MURMUR3_32_STREAM_HASH_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define M3H_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("m3h same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define M3H_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("m3h next-cycle check failed");

`endif

FILE: src/m3h_pkg.sv
// Types and constants of the murmur3 x86_32 stream hash.
// Used by m3h_ctrl, m3h_datapath and the top level; depends on nothing.
package m3h_pkg;

    localparam logic [31:0] MIX_C1    = 32'hcc9e2d51;
    localparam logic [31:0] MIX_C2    = 32'h1b873593;
    localparam logic [31:0] ROUND_ADD = 32'he6546b64;
    localparam logic [31:0] FIN_M1    = 32'h85ebca6b;
    localparam logic [31:0] FIN_M2    = 32'hc2b2ae35;

    // Operand selection of the shared multiplier.
    typedef enum logic [1:0] {
        MUL_KEY1 = 2'd0,
        MUL_KEY2 = 2'd1,
        MUL_FIN1 = 2'd2,
        MUL_FIN2 = 2'd3
    } mul_op_t;

    typedef struct packed {
        logic    load;
        logic    start;
        logic    mul_en;
        mul_op_t mul_op;
        logic    round_en;
        logic    out_en;
    } cmd_t;

    typedef struct packed {
        logic end_item;
        logic has_bytes;
    } status_t;

endpackage

FILE: src/m3h_datapath.sv
// Datapath of the murmur3 stream hash: seed, running hash, byte total,
// one shared 32x32 multiplier and the result register. Depends on m3h_pkg.
module m3h_datapath (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             seed_wr_en,
    input  logic [31:0]      seed_wr_data,
    input  logic [31:0]      in_word,
    input  logic [2:0]       in_count,
    input  logic             in_last,
    input  m3h_pkg::cmd_t    cmd,
    output m3h_pkg::status_t status,
    output logic [31:0]      out_hash,
    output logic [31:0]      out_len
);

    logic [31:0] seed_reg;
    logic [31:0] word_reg;
    logic [2:0]  n_reg;
    logic        end_reg;
    logic [31:0] hash_reg;
    logic [31:0] total_reg;
    logic [31:0] tmp_reg;
    logic [31:0] out_hash_reg;
    logic [31:0] out_len_reg;

    logic [2:0]  n_clamp;
    logic [31:0] byte_mask;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [31:0] prod;
    logic [31:0] fin_x;
    logic [31:0] hx;
    logic [31:0] hrot;
    logic [31:0] hash_next;

    // Counts of five to seven mean a full word.
    assign n_clamp = (in_count > 3'd4) ? 3'd4 : in_count;

    always_comb begin
        unique case (n_clamp)
            3'd0:    byte_mask = 32'h00000000;
            3'd1:    byte_mask = 32'h000000ff;
            3'd2:    byte_mask = 32'h0000ffff;
            3'd3:    byte_mask = 32'h00ffffff;
            default: byte_mask = 32'hffffffff;
        endcase
    end

    assign fin_x = hash_reg ^ total_reg;

    always_comb begin
        unique case (cmd.mul_op)
            m3h_pkg::MUL_KEY1: begin
                mul_a = word_reg;
                mul_b = m3h_pkg::MIX_C1;
            end
            m3h_pkg::MUL_KEY2: begin
                mul_a = {tmp_reg[16:0], tmp_reg[31:17]};
                mul_b = m3h_pkg::MIX_C2;
            end
            m3h_pkg::MUL_FIN1: begin
                mul_a = fin_x ^ (fin_x >> 16);
                mul_b = m3h_pkg::FIN_M1;
            end
            default: begin
                mul_a = tmp_reg ^ (tmp_reg >> 13);
                mul_b = m3h_pkg::FIN_M2;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // Body round: xor, then for a full word rotate left by 13, times five plus a constant.
    assign hx   = hash_reg ^ tmp_reg;
    assign hrot = {hx[18:0], hx[31:19]};
    assign hash_next = (n_reg == 3'd4) ? (hrot + {hrot[29:0], 2'b00} + m3h_pkg::ROUND_ADD)
                                       : hx;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= 32'd0;
        end else if (seed_wr_en) begin
            seed_reg <= seed_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            word_reg  <= in_word & byte_mask;
            n_reg     <= n_clamp;
            end_reg   <= in_last | (n_clamp != 3'd4);
            total_reg <= (cmd.start ? 32'd0 : total_reg) + {29'd0, n_clamp};
            if (cmd.start) begin
                hash_reg <= seed_reg;
            end
        end else if (cmd.round_en) begin
            hash_reg <= hash_next;
        end
        if (cmd.mul_en) begin
            tmp_reg <= prod;
        end
        if (cmd.out_en) begin
            out_hash_reg <= tmp_reg ^ (tmp_reg >> 16);
            out_len_reg  <= total_reg;
        end
    end

    assign status.end_item  = end_reg;
    assign status.has_bytes = (n_reg != 3'd0);
    assign out_hash = out_hash_reg;
    assign out_len  = out_len_reg;

endmodule

FILE: src/m3h_ctrl.sv
// Controller of the murmur3 stream hash: sequences key mix, body round and
// finalizer, and owns the handshakes. Depends on m3h_pkg and the defines header.
`include "murmur3_32_stream_hash_defines.svh"

module m3h_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  logic             m_tready,
    input  m3h_pkg::status_t status,
    output m3h_pkg::cmd_t    cmd
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_KM1  = 7'b0000010,
        S_KM2  = 7'b0000100,
        S_RND  = 7'b0001000,
        S_FIN1 = 7'b0010000,
        S_FIN2 = 7'b0100000,
        S_FIN3 = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   in_msg_reg, in_msg_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;
    logic   out_free;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.load     = accept;
        cmd.start    = accept && !in_msg_reg;
        cmd.mul_op   = m3h_pkg::MUL_KEY1;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_KM1;
                end
            end
            S_KM1: begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = m3h_pkg::MUL_KEY1;
                // An empty final beat skips the second key multiply and the body round.
                state_next = status.has_bytes ? S_KM2 : S_FIN1;
            end
            S_KM2: begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = m3h_pkg::MUL_KEY2;
                state_next = S_RND;
            end
            S_RND: begin
                cmd.round_en = 1'b1;
                state_next   = status.end_item ? S_FIN1 : S_IDLE;
            end
            S_FIN1: begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = m3h_pkg::MUL_FIN1;
                state_next = S_FIN2;
            end
            S_FIN2: begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = m3h_pkg::MUL_FIN2;
                state_next = S_FIN3;
            end
            S_FIN3: begin
                if (out_free) begin
                    cmd.out_en = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        in_msg_next = in_msg_reg;
        if (accept) begin
            in_msg_next = 1'b1;
        end else if (cmd.out_en) begin
            in_msg_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (cmd.out_en) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            in_msg_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            in_msg_reg    <= in_msg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // A pending result is never overwritten.
    `M3H_ASSERT_IMP(a_no_overwrite, out_valid_reg && !m_tready, !cmd.out_en)
    // While an item is being worked on, a message is open.
    `M3H_ASSERT_IMP(a_busy_in_msg, state_reg != S_IDLE, in_msg_reg)
    // Writing a result closes the message and presents the beat.
    `M3H_ASSERT_NXT(a_out_closes, cmd.out_en, m_tvalid && !in_msg_reg)

endmodule

FILE: src/murmur3_32_stream_hash.sv
// Channel | Direction | tdata fields (low bit up)                 | tlast
// s_      | in        | data_word[31:0], byte_count[34:32], pad     | last
// m_      | out       | hash_value[31:0], message_length[63:32]     | none
// seed_wr | cfg       | seed[31:0] on seed_wr_data, seed_wr_en      | none
//
// A full word that does not end a message runs the key mix and the body round
// before a new beat is accepted; a message-ending beat also runs the finalizer.
// The sequence is set by the single shared multiplier: two products for the key
// mix and two for the finalizer, each registered. aresetn is synchronous, active
// low, and clears the seed to zero. A result waits in its own register, so a new
// beat is accepted while m_tready is low; only a second result waits for it.
module murmur3_32_stream_hash (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // data_word[31:0], byte_count[34:32], zero[39:35]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // hash_value[31:0], message_length[63:32]
    input  logic        seed_wr_en,
    input  logic [31:0] seed_wr_data
);

    m3h_pkg::cmd_t    cmd;
    m3h_pkg::status_t status;
    logic [31:0]      out_hash;
    logic [31:0]      out_len;

    m3h_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    m3h_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .seed_wr_en   (seed_wr_en),
        .seed_wr_data (seed_wr_data),
        .in_word      (s_tdata[31:0]),
        .in_count     (s_tdata[34:32]),
        .in_last      (s_tlast),
        .cmd          (cmd),
        .status       (status),
        .out_hash     (out_hash),
        .out_len      (out_len)
    );

    assign m_tdata = {out_len, out_hash};

endmodule

FILE: test/tb.sv
// Self-checking testbench for murmur3_32_stream_hash: whole messages are streamed in,
// and each hash and byte count is compared against an in-bench MurmurHash3 x86_32 model.
// Depends only on the RTL top level murmur3_32_stream_hash.
`timescale 1ns / 100ps

module tb;

    typedef struct {
        logic [31:0] hash;
        logic [31:0] length;
    } digest_t;

    class hash_scoreboard;
        localparam logic [31:0] K1 = 32'hcc9e2d51;
        localparam logic [31:0] K2 = 32'h1b873593;
        localparam logic [31:0] BODY_ADD = 32'he6546b64;
        localparam logic [31:0] AVAL_M1 = 32'h85ebca6b;
        localparam logic [31:0] AVAL_M2 = 32'hc2b2ae35;

        logic [31:0] seed_reg = '0;
        logic [31:0] running_hash = '0;
        logic [31:0] bytes_so_far = '0;
        bit          msg_open = 1'b0;
        digest_t     expected_digests[$];
        int          errors = 0;

        function logic [31:0] scramble_key(logic [31:0] k);
            logic [31:0] t;
            t = k * K1;
            t = {t[16:0], t[31:17]};
            return t * K2;
        endfunction

        function logic [31:0] avalanche(logic [31:0] h);
            logic [31:0] t;
            t = h ^ (h >> 16);
            t = t * AVAL_M1;
            t = t ^ (t >> 13);
            t = t * AVAL_M2;
            return t ^ (t >> 16);
        endfunction

        function void set_seed(logic [31:0] v);
            seed_reg = v;
        endfunction

        function int pending();
            return expected_digests.size();
        endfunction

        // Called for every accepted input beat.
        function void note_beat(logic [31:0] word, logic [2:0] cnt, logic last);
            int unsigned nbytes;
            logic [31:0] h;
            bit          ends;
            digest_t     d;
            nbytes = (cnt > 3'd4) ? 4 : cnt;
            if (!msg_open) begin
                running_hash = seed_reg;
                bytes_so_far = '0;
                msg_open = 1'b1;
            end
            h = running_hash;
            ends = last;
            if (nbytes == 4) begin
                h = h ^ scramble_key(word);
                h = {h[18:0], h[31:19]};
                h = h * 32'd5 + BODY_ADD;
            end else begin
                // A short beat always closes the message, marked last or not.
                ends = 1'b1;
                if (nbytes != 0)
                    h = h ^ scramble_key(word & ((32'h1 << (8 * nbytes)) - 32'h1));
            end
            bytes_so_far = bytes_so_far + nbytes;
            running_hash = h;
            if (ends) begin
                d.hash = avalanche(h ^ bytes_so_far);
                d.length = bytes_so_far;
                expected_digests.push_back(d);
                msg_open = 1'b0;
            end
        endfunction

        function void check_result(logic [63:0] beat);
            digest_t d;
            if (expected_digests.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, hash %h length %h",
                         $time, beat[31:0], beat[63:32]);
                return;
            end
            d = expected_digests.pop_front();
            if (beat[31:0] !== d.hash) begin
                errors++;
                $display("%0t: hash_value expected %h actual %h", $time, d.hash, beat[31:0]);
            end
            if (beat[63:32] !== d.length) begin
                errors++;
                $display("%0t: message_length expected %h actual %h",
                         $time, d.length, beat[63:32]);
            end
        endfunction
    endclass

    localparam int CYCLE_LIMIT = 500000;
    localparam int DRAIN_CYCLES = 12;
    localparam int PHASE_BEATS = 240;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic        seed_wr_en = 1'b0;
    logic [31:0] seed_wr_data = '0;

    hash_scoreboard sb = new;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int cycles = 0;

    murmur3_32_stream_hash u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .seed_wr_en   (seed_wr_en),
        .seed_wr_data (seed_wr_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Result side: check accepted beats, then decide the next stall.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata);
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function logic [31:0] pick_word();
        case ($urandom_range(15))
            0: return 32'h0000_0000;
            1: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // All driving tasks are entered just after a rising edge.
    task send_beat(logic [31:0] word, logic [2:0] cnt, logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {5'b0, cnt, word};
        s_tlast <= last;
        do
            @(posedge aclk);
        while (!s_tready);
        sb.note_beat(word, cnt, last);
    endtask

    task drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task write_seed(logic [31:0] v);
        seed_wr_en <= 1'b1;
        seed_wr_data <= v;
        @(posedge aclk);
        seed_wr_en <= 1'b0;
        sb.set_seed(v);
    endtask

    // Mostly well-formed messages; now and then a short beat without last cuts one off.
    task send_random_message(output int beats);
        int body;
        logic [2:0] cnt;
        body = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(6);
        beats = body + 1;
        for (int i = 0; i < body; i++) begin
            cnt = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 5)) : 3'd4;
            send_beat(pick_word(), cnt, 1'b0);
        end
        case ($urandom_range(9))
            0: send_beat(pick_word(), 3'($urandom_range(3)), 1'b0);
            1, 2: send_beat(pick_word(), 3'($urandom_range(7, 4)), 1'b1);
            default: send_beat(pick_word(), 3'($urandom_range(3)), 1'b1);
        endcase
    endtask

    task run_phase(int idle_pct, int stall_pct, logic [31:0] seed_val);
        int sent;
        int n;
        write_seed(seed_val);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < PHASE_BEATS) begin
            send_random_message(n);
            sent += n;
        end
        drain();
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part with the reset seed of zero.
        send_beat(32'h0000_0000, 3'd0, 1'b1);
        send_beat(32'hffff_ffff, 3'd4, 1'b1);
        send_beat(32'hffff_ffff, 3'd1, 1'b1);
        send_beat(32'hffff_ffff, 3'd2, 1'b1);
        send_beat(32'hffff_ffff, 3'd3, 1'b1);
        send_beat(32'h1234_5678, 3'd4, 1'b0);
        send_beat(32'ha5a5_a5a5, 3'd7, 1'b0);
        send_beat(32'h5a5a_5a5a, 3'd5, 1'b0);
        send_beat(32'hffff_ffff, 3'd6, 1'b1);
        send_beat(32'h0000_0000, 3'd4, 1'b0);
        send_beat(32'hdead_beef, 3'd2, 1'b0);
        send_beat(32'h8000_0001, 3'd3, 1'b0);
        send_beat(32'hffff_ffff, 3'd0, 1'b0);
        send_beat(32'hcafe_f00d, 3'd4, 1'b0);

        // The message is still open here; the new seed must only affect the next one.
        drain();
        write_seed(32'hffff_ffff);
        send_beat(32'h1122_3344, 3'd4, 1'b1);
        send_beat(32'h0000_0000, 3'd0, 1'b1);
        send_beat(32'h7f7f_7f7f, 3'd3, 1'b1);
        drain();

        run_phase(0, 0, 32'hffff_ffff);
        run_phase(64, 0, 32'h0000_0000);
        run_phase(0, 64, $urandom);
        run_phase(14, 14, $urandom);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

FILE: murmur3_32_stream_hash.f
+incdir+src
src/m3h_pkg.sv
src/m3h_datapath.sv
src/m3h_ctrl.sv
src/murmur3_32_stream_hash.sv
test/tb.sv
